// ----- rtl/core/vsrc_pkg.sv -----
package vsrc_pkg;

  // Default values for the top-level parameters.
  localparam int POWER_BITS_DEF  = 24;
  localparam int COUNT_LIMIT_DEF = 10;
  localparam int FRAC_BITS_DEF   = 16;

  // Fixed field widths.
  localparam int FLAGS_W   = 6;
  localparam int SPO2_W    = 7;
  localparam int HR_W      = 8;
  localparam int SQ_W      = 8;
  localparam int DAR_W     = 16;
  localparam int PCT_W     = 7;
  localparam int SCORE_W   = 7;
  localparam int MASK_W    = 5;
  localparam int LEVEL_W   = 2;
  localparam int CNT_W     = 4;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int PTS_W     = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SPO2_HYPOXIA   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HR_BRADY       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HR_TACHY       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DAR_ALERT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_DOM      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE    = 3'd5;

  // Configuration reset values.
  localparam logic [SPO2_W-1:0] RST_SPO2_HYPOXIA = 7'd92;
  localparam logic [HR_W-1:0]   RST_HR_BRADY     = 8'd40;
  localparam logic [HR_W-1:0]   RST_HR_TACHY     = 8'd150;
  localparam logic [DAR_W-1:0]  RST_DAR_ALERT    = 16'd768;
  localparam logic [PCT_W-1:0]  RST_DELTA_DOM    = 7'd50;
  localparam logic [CNT_W-1:0]  RST_PERSISTENCE  = 4'd4;

  // Sensor flag bit positions.
  localparam int FLAG_IMU      = 0;
  localparam int FLAG_FALL     = 1;
  localparam int FLAG_PPG      = 2;
  localparam int FLAG_ATTACHED = 3;
  localparam int FLAG_EEG      = 4;
  localparam int FLAG_SYNCED   = 5;

  // Reason mask bit positions.
  localparam int RSN_FALL      = 0;
  localparam int RSN_HYPOXIA   = 1;
  localparam int RSN_ARRHYTHM  = 2;
  localparam int RSN_DAR       = 3;
  localparam int RSN_DELTA     = 4;

  // Anomaly points and score limits.
  localparam logic [PTS_W-1:0]   PTS_FALL     = 8'd50;
  localparam logic [PTS_W-1:0]   PTS_HYPOXIA  = 8'd30;
  localparam logic [PTS_W-1:0]   PTS_ARRHYTHM = 8'd25;
  localparam logic [PTS_W-1:0]   PTS_DAR      = 8'd35;
  localparam logic [PTS_W-1:0]   PTS_DELTA    = 8'd20;
  localparam logic [PTS_W-1:0]   RAW_MAX      = 8'd100;
  localparam logic [SQ_W-1:0]    SQ_CLEAN_MAX = 8'd50;
  localparam logic [PCT_W-1:0]   PCT_SCALE    = 7'd100;

  // Exponential average weights, out of 2^W_SHIFT.
  localparam int W_KEEP   = 42598;
  localparam int W_NEW    = 22938;
  localparam int W_NEW_W  = 15;
  localparam int W_SHIFT  = 16;

  // Level decision thresholds.
  localparam logic [SCORE_W-1:0] ANOM_RAW    = 7'd30;
  localparam logic [SCORE_W-1:0] CRIT_FIN    = 7'd60;
  localparam logic [SCORE_W-1:0] CRIT_FLOOR  = 7'd75;
  localparam logic [SCORE_W-1:0] WARN_FIN    = 7'd30;
  localparam logic [SCORE_W-1:0] REPORT_FIN  = 7'd25;

  // Risk level codes.
  localparam logic [LEVEL_W-1:0] LEVEL_NORMAL   = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_WARNING  = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_CRITICAL = 2'd2;

  typedef struct packed {
    logic [SPO2_W-1:0] spo2_hypoxia_pct;
    logic [HR_W-1:0]   hr_brady_bpm;
    logic [HR_W-1:0]   hr_tachy_bpm;
    logic [DAR_W-1:0]  dar_alert_level;
    logic [PCT_W-1:0]  delta_dominance_pct;
    logic [CNT_W-1:0]  persistence_samples;
  } cfg_t;

  // Per-sample anomaly result.
  typedef struct packed {
    logic               fall;
    logic [MASK_W-1:0]  mask;
    logic [SCORE_W-1:0] raw;
  } score_t;

  // Per-sample result after the state update.
  typedef struct packed {
    logic               fall;
    logic [MASK_W-1:0]  mask;
    logic [SCORE_W-1:0] raw;
    logic [SCORE_W-1:0] fin;
    logic [CNT_W-1:0]   count;
  } trend_t;

endpackage

// ----- rtl/core/vsrc_cfg_regs.sv -----
module vsrc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [vsrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vsrc_pkg::CFG_W-1:0]         cfg_data,
  output vsrc_pkg::cfg_t                     cfg
);

  vsrc_pkg::cfg_t cfg_r;
  vsrc_pkg::cfg_t cfg_nxt;

  // Decode the write; unknown indexes leave every register alone.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        vsrc_pkg::REG_SPO2_HYPOXIA:
          cfg_nxt.spo2_hypoxia_pct = cfg_data[vsrc_pkg::SPO2_W-1:0];
        vsrc_pkg::REG_HR_BRADY:
          cfg_nxt.hr_brady_bpm = cfg_data[vsrc_pkg::HR_W-1:0];
        vsrc_pkg::REG_HR_TACHY:
          cfg_nxt.hr_tachy_bpm = cfg_data[vsrc_pkg::HR_W-1:0];
        vsrc_pkg::REG_DAR_ALERT:
          cfg_nxt.dar_alert_level = cfg_data[vsrc_pkg::DAR_W-1:0];
        vsrc_pkg::REG_DELTA_DOM:
          cfg_nxt.delta_dominance_pct = cfg_data[vsrc_pkg::PCT_W-1:0];
        vsrc_pkg::REG_PERSISTENCE:
          cfg_nxt.persistence_samples = cfg_data[vsrc_pkg::CNT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  // Registers with their power-on thresholds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spo2_hypoxia_pct    <= vsrc_pkg::RST_SPO2_HYPOXIA;
      cfg_r.hr_brady_bpm        <= vsrc_pkg::RST_HR_BRADY;
      cfg_r.hr_tachy_bpm        <= vsrc_pkg::RST_HR_TACHY;
      cfg_r.dar_alert_level     <= vsrc_pkg::RST_DAR_ALERT;
      cfg_r.delta_dominance_pct <= vsrc_pkg::RST_DELTA_DOM;
      cfg_r.persistence_samples <= vsrc_pkg::RST_PERSISTENCE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/vsrc_detect.sv -----
module vsrc_detect #(
  parameter int POWER_BITS = vsrc_pkg::POWER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              ld_a,
  input  logic                              ld_b,
  input  vsrc_pkg::cfg_t                    cfg,
  input  logic [vsrc_pkg::FLAGS_W-1:0]      sensor_flags,
  input  logic [vsrc_pkg::SPO2_W-1:0]       spo2_pct,
  input  logic [vsrc_pkg::HR_W-1:0]         heart_rate,
  input  logic [vsrc_pkg::SQ_W-1:0]         signal_quality,
  input  logic [vsrc_pkg::DAR_W-1:0]        dar_ratio,
  input  logic [POWER_BITS-1:0]             delta_power,
  input  logic [POWER_BITS-1:0]             theta_power,
  input  logic [POWER_BITS-1:0]             low_alpha_power,
  input  logic [POWER_BITS-1:0]             high_alpha_power,
  input  logic [POWER_BITS-1:0]             low_beta_power,
  input  logic [POWER_BITS-1:0]             high_beta_power,
  output vsrc_pkg::score_t                  score
);

  localparam int TOT_W  = POWER_BITS + 3;
  localparam int D100_W = POWER_BITS + vsrc_pkg::PCT_W;
  localparam int PROD_W = TOT_W + vsrc_pkg::PCT_W;

  logic              fall;
  logic              ppg_ok;
  logic              eeg_ok;
  logic              hyp;
  logic              arr;
  logic              dar_hi;
  logic [TOT_W-1:0]  total;
  logic [D100_W-1:0] delta100;

  logic              fall_r;
  logic              eeg_ok_r;
  logic              hyp_r;
  logic              arr_r;
  logic              dar_hi_r;
  logic [TOT_W-1:0]  total_r;
  logic [D100_W-1:0] delta100_r;

  logic [PROD_W-1:0]          share_lim;
  logic                       dom;
  logic [vsrc_pkg::PTS_W-1:0] raw_sum;
  vsrc_pkg::score_t           score_nxt;
  vsrc_pkg::score_t           score_r;

  // First stage: sensor gating, threshold tests, band total and scaled delta.
  always_comb begin
    fall   = sensor_flags[vsrc_pkg::FLAG_IMU] & sensor_flags[vsrc_pkg::FLAG_FALL];
    ppg_ok = sensor_flags[vsrc_pkg::FLAG_PPG] & sensor_flags[vsrc_pkg::FLAG_ATTACHED];
    eeg_ok = sensor_flags[vsrc_pkg::FLAG_EEG] & sensor_flags[vsrc_pkg::FLAG_SYNCED] &
             (signal_quality <= vsrc_pkg::SQ_CLEAN_MAX);
    hyp    = ppg_ok && (spo2_pct != '0) && (spo2_pct < cfg.spo2_hypoxia_pct);
    arr    = ppg_ok && (heart_rate != '0) &&
             ((heart_rate < cfg.hr_brady_bpm) || (heart_rate > cfg.hr_tachy_bpm));
    dar_hi = eeg_ok && (dar_ratio >= cfg.dar_alert_level);
    total  = TOT_W'(delta_power) + TOT_W'(theta_power) + TOT_W'(low_alpha_power) +
             TOT_W'(high_alpha_power) + TOT_W'(low_beta_power) + TOT_W'(high_beta_power);
    delta100 = D100_W'(delta_power) * D100_W'(vsrc_pkg::PCT_SCALE);
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      fall_r     <= fall;
      eeg_ok_r   <= eeg_ok;
      hyp_r      <= hyp;
      arr_r      <= arr;
      dar_hi_r   <= dar_hi;
      total_r    <= total;
      delta100_r <= delta100;
    end
  end

  // Second stage: delta dominance test and the saturated point sum.
  always_comb begin
    share_lim = PROD_W'(cfg.delta_dominance_pct) * PROD_W'(total_r);
    dom       = eeg_ok_r && (total_r != '0) && (PROD_W'(delta100_r) > share_lim);
    raw_sum   = (fall_r   ? vsrc_pkg::PTS_FALL     : '0) +
                (hyp_r    ? vsrc_pkg::PTS_HYPOXIA  : '0) +
                (arr_r    ? vsrc_pkg::PTS_ARRHYTHM : '0) +
                (dar_hi_r ? vsrc_pkg::PTS_DAR      : '0) +
                (dom      ? vsrc_pkg::PTS_DELTA    : '0);
    score_nxt.fall = fall_r;
    score_nxt.mask = '0;
    score_nxt.mask[vsrc_pkg::RSN_FALL]     = fall_r;
    score_nxt.mask[vsrc_pkg::RSN_HYPOXIA]  = hyp_r;
    score_nxt.mask[vsrc_pkg::RSN_ARRHYTHM] = arr_r;
    score_nxt.mask[vsrc_pkg::RSN_DAR]      = dar_hi_r;
    score_nxt.mask[vsrc_pkg::RSN_DELTA]    = dom;
    score_nxt.raw = (raw_sum > vsrc_pkg::RAW_MAX) ?
                    vsrc_pkg::RAW_MAX[vsrc_pkg::SCORE_W-1:0] :
                    raw_sum[vsrc_pkg::SCORE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld_b) begin
      score_r <= score_nxt;
    end
  end

  assign score = score_r;

endmodule

// ----- rtl/core/vsrc_trend.sv -----
module vsrc_trend #(
  parameter int COUNT_LIMIT = vsrc_pkg::COUNT_LIMIT_DEF,
  parameter int FRAC_BITS   = vsrc_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              upd,
  input  vsrc_pkg::score_t  score,
  output vsrc_pkg::trend_t  trend
);

  localparam int SM_W   = vsrc_pkg::SCORE_W + FRAC_BITS;
  localparam int SUM_W  = SM_W + vsrc_pkg::W_SHIFT + 1;
  localparam int NEWP_W = vsrc_pkg::SCORE_W + vsrc_pkg::W_NEW_W;

  logic [vsrc_pkg::CNT_W-1:0] count_r;
  logic [vsrc_pkg::CNT_W-1:0] count_nxt;
  logic [SM_W-1:0]            smooth_r;
  logic [SM_W-1:0]            smooth_nxt;
  logic [SUM_W-1:0]           keep_term;
  logic [NEWP_W-1:0]          new_pts;
  logic [SUM_W-1:0]           new_term;
  logic [SUM_W-1:0]           avg_sum;
  vsrc_pkg::trend_t           trend_r;
  vsrc_pkg::trend_t           trend_nxt;

  // Persistence counter: up on an anomalous sample, down otherwise, saturating.
  always_comb begin
    count_nxt = count_r;
    if (score.raw >= vsrc_pkg::ANOM_RAW) begin
      if (count_r < vsrc_pkg::CNT_W'(COUNT_LIMIT)) begin
        count_nxt = count_r + 1'b1;
      end
    end else if (count_r != '0) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Exponential average in fixed point, truncated after the weight shift.
  always_comb begin
    keep_term  = SUM_W'(smooth_r) * SUM_W'(vsrc_pkg::W_KEEP);
    new_pts    = NEWP_W'(score.raw) * NEWP_W'(vsrc_pkg::W_NEW);
    new_term   = SUM_W'(new_pts) << FRAC_BITS;
    avg_sum    = keep_term + new_term;
    smooth_nxt = SM_W'(avg_sum >> vsrc_pkg::W_SHIFT);
  end

  always_comb begin
    trend_nxt.fall  = score.fall;
    trend_nxt.mask  = score.mask;
    trend_nxt.raw   = score.raw;
    trend_nxt.fin   = smooth_nxt[SM_W-1 -: vsrc_pkg::SCORE_W];
    trend_nxt.count = count_nxt;
  end

  // State moves exactly once per sample, as it enters this stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      smooth_r <= '0;
    end else if (upd) begin
      count_r  <= count_nxt;
      smooth_r <= smooth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      trend_r <= trend_nxt;
    end
  end

  assign trend = trend_r;

endmodule

// ----- rtl/core/vsrc_grade.sv -----
module vsrc_grade (
  input  logic                             clk,
  input  logic                             ld,
  input  logic [vsrc_pkg::CNT_W-1:0]       persistence_samples,
  input  vsrc_pkg::trend_t                 trend,
  output logic [vsrc_pkg::LEVEL_W-1:0]     risk_level,
  output logic [vsrc_pkg::SCORE_W-1:0]     risk_score,
  output logic [vsrc_pkg::MASK_W-1:0]      reason_mask,
  output logic [vsrc_pkg::SCORE_W-1:0]     raw_score
);

  logic                             persistent;
  logic [vsrc_pkg::LEVEL_W-1:0]     level_nxt;
  logic [vsrc_pkg::SCORE_W-1:0]     score_nxt;
  logic [vsrc_pkg::LEVEL_W-1:0]     level_r;
  logic [vsrc_pkg::SCORE_W-1:0]     score_r;
  logic [vsrc_pkg::MASK_W-1:0]      mask_r;
  logic [vsrc_pkg::SCORE_W-1:0]     raw_r;

  // Level from the averaged score and persistence; a fall is always critical.
  always_comb begin
    persistent = (trend.count >= persistence_samples);
    if (trend.fall || ((trend.fin >= vsrc_pkg::CRIT_FIN) && persistent)) begin
      level_nxt = vsrc_pkg::LEVEL_CRITICAL;
      score_nxt = (trend.fin > vsrc_pkg::CRIT_FIN) ? trend.fin : vsrc_pkg::CRIT_FLOOR;
    end else if ((trend.fin >= vsrc_pkg::WARN_FIN) && persistent) begin
      level_nxt = vsrc_pkg::LEVEL_WARNING;
      score_nxt = trend.fin;
    end else begin
      level_nxt = vsrc_pkg::LEVEL_NORMAL;
      score_nxt = (trend.fin < vsrc_pkg::REPORT_FIN) ? '0 : (trend.fin >> 1);
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (ld) begin
      level_r <= level_nxt;
      score_r <= score_nxt;
      mask_r  <= trend.mask;
      raw_r   <= trend.raw;
    end
  end

  assign risk_level  = level_r;
  assign risk_score  = score_r;
  assign reason_mask = mask_r;
  assign raw_score   = raw_r;

endmodule

// ----- rtl/core/vital_sign_risk_classifier.sv -----
// Vital sign risk classifier.
// Input channel (in_*): one fused sensor word per transfer, taken at a rising
// edge where in_valid is high and in_stall is low. Output channel (out_*):
// one result word per input word, in order, taken where out_valid is high and
// out_stall is low. Thresholds are written through cfg_we/cfg_index/cfg_data
// while no word is in flight; unknown indexes are ignored.
// A word accepted at one edge moves in order through the five register ranks
// (input, test, score, average, output) and then shows on out_*. The pipeline
// takes one word every cycle while the receiver does not stall; the average
// update is the only loop and closes within one stage.
// Reset (rst_n low, synchronous) empties the pipeline, clears the persistence
// counter and the score average and loads the default thresholds.
// When the receiver stalls, the result word holds on out_* and the pipeline
// keeps filling its empty stages; in_stall rises only once every stage holds
// a word, and goes low again in the cycle the output word is taken.
module vital_sign_risk_classifier #(
  parameter int POWER_BITS  = vsrc_pkg::POWER_BITS_DEF,
  parameter int COUNT_LIMIT = vsrc_pkg::COUNT_LIMIT_DEF,
  parameter int FRAC_BITS   = vsrc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [vsrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vsrc_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [vsrc_pkg::FLAGS_W-1:0]      in_sensor_flags,
  input  logic [vsrc_pkg::SPO2_W-1:0]       in_spo2_pct,
  input  logic [vsrc_pkg::HR_W-1:0]         in_heart_rate,
  input  logic [vsrc_pkg::SQ_W-1:0]         in_signal_quality,
  input  logic [vsrc_pkg::DAR_W-1:0]        in_dar_ratio,
  input  logic [POWER_BITS-1:0]             in_delta_power,
  input  logic [POWER_BITS-1:0]             in_theta_power,
  input  logic [POWER_BITS-1:0]             in_low_alpha_power,
  input  logic [POWER_BITS-1:0]             in_high_alpha_power,
  input  logic [POWER_BITS-1:0]             in_low_beta_power,
  input  logic [POWER_BITS-1:0]             in_high_beta_power,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [vsrc_pkg::LEVEL_W-1:0]      out_risk_level,
  output logic [vsrc_pkg::SCORE_W-1:0]      out_risk_score,
  output logic [vsrc_pkg::MASK_W-1:0]       out_reason_mask,
  output logic [vsrc_pkg::SCORE_W-1:0]      out_raw_score
);

  vsrc_pkg::cfg_t   cfg;
  vsrc_pkg::score_t score;
  vsrc_pkg::trend_t trend;

  // Stage valid bits, from input register to output register.
  logic v_in_r, v_in_nxt;
  logic v_a_r,  v_a_nxt;
  logic v_b_r,  v_b_nxt;
  logic v_c_r,  v_c_nxt;
  logic out_valid_r, out_valid_nxt;

  logic rdy_in, rdy_a, rdy_b, rdy_c, rdy_out;
  logic ld_in, ld_a, ld_b, ld_c, ld_out;

  // Input word register.
  logic [vsrc_pkg::FLAGS_W-1:0] flags_r;
  logic [vsrc_pkg::SPO2_W-1:0]  spo2_r;
  logic [vsrc_pkg::HR_W-1:0]    hr_r;
  logic [vsrc_pkg::SQ_W-1:0]    sq_r;
  logic [vsrc_pkg::DAR_W-1:0]   dar_r;
  logic [POWER_BITS-1:0]        delta_r;
  logic [POWER_BITS-1:0]        theta_r;
  logic [POWER_BITS-1:0]        low_alpha_r;
  logic [POWER_BITS-1:0]        high_alpha_r;
  logic [POWER_BITS-1:0]        low_beta_r;
  logic [POWER_BITS-1:0]        high_beta_r;

  // A stage may load when it is empty or its word moves on this cycle.
  always_comb begin
    rdy_out = !out_valid_r || !out_stall;
    rdy_c   = !v_c_r  || rdy_out;
    rdy_b   = !v_b_r  || rdy_c;
    rdy_a   = !v_a_r  || rdy_b;
    rdy_in  = !v_in_r || rdy_a;
    ld_in   = in_valid && rdy_in;
    ld_a    = v_in_r && rdy_a;
    ld_b    = v_a_r  && rdy_b;
    ld_c    = v_b_r  && rdy_c;
    ld_out  = v_c_r  && rdy_out;
    v_in_nxt      = rdy_in  ? in_valid : v_in_r;
    v_a_nxt       = rdy_a   ? v_in_r   : v_a_r;
    v_b_nxt       = rdy_b   ? v_a_r    : v_b_r;
    v_c_nxt       = rdy_c   ? v_b_r    : v_c_r;
    out_valid_nxt = rdy_out ? v_c_r    : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_in_r      <= 1'b0;
      v_a_r       <= 1'b0;
      v_b_r       <= 1'b0;
      v_c_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v_in_r      <= v_in_nxt;
      v_a_r       <= v_a_nxt;
      v_b_r       <= v_b_nxt;
      v_c_r       <= v_c_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_in) begin
      flags_r      <= in_sensor_flags;
      spo2_r       <= in_spo2_pct;
      hr_r         <= in_heart_rate;
      sq_r         <= in_signal_quality;
      dar_r        <= in_dar_ratio;
      delta_r      <= in_delta_power;
      theta_r      <= in_theta_power;
      low_alpha_r  <= in_low_alpha_power;
      high_alpha_r <= in_high_alpha_power;
      low_beta_r   <= in_low_beta_power;
      high_beta_r  <= in_high_beta_power;
    end
  end

  assign in_stall  = !rdy_in;
  assign out_valid = out_valid_r;

  vsrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vsrc_detect #(
    .POWER_BITS (POWER_BITS)
  ) u_detect (
    .clk              (clk),
    .ld_a             (ld_a),
    .ld_b             (ld_b),
    .cfg              (cfg),
    .sensor_flags     (flags_r),
    .spo2_pct         (spo2_r),
    .heart_rate       (hr_r),
    .signal_quality   (sq_r),
    .dar_ratio        (dar_r),
    .delta_power      (delta_r),
    .theta_power      (theta_r),
    .low_alpha_power  (low_alpha_r),
    .high_alpha_power (high_alpha_r),
    .low_beta_power   (low_beta_r),
    .high_beta_power  (high_beta_r),
    .score            (score)
  );

  vsrc_trend #(
    .COUNT_LIMIT (COUNT_LIMIT),
    .FRAC_BITS   (FRAC_BITS)
  ) u_trend (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (ld_c),
    .score (score),
    .trend (trend)
  );

  vsrc_grade u_grade (
    .clk                 (clk),
    .ld                  (ld_out),
    .persistence_samples (cfg.persistence_samples),
    .trend               (trend),
    .risk_level          (out_risk_level),
    .risk_score          (out_risk_score),
    .reason_mask         (out_reason_mask),
    .raw_score           (out_raw_score)
  );

endmodule

// ----- test/tb_vital_sign_risk_classifier.sv -----
module tb_vital_sign_risk_classifier;
  import vsrc_pkg::*;

  localparam int PW        = POWER_BITS_DEF;
  localparam int CNT_LIMIT = COUNT_LIMIT_DEF;
  localparam int FRAC      = FRAC_BITS_DEF;

  // Sensor flag and reason bit positions.
  localparam int F_IMU  = 0;
  localparam int F_FALL = 1;
  localparam int F_PPG  = 2;
  localparam int F_ATT  = 3;
  localparam int F_EEG  = 4;
  localparam int F_SYNC = 5;
  localparam int R_FALL  = 0;
  localparam int R_HYPOX = 1;
  localparam int R_ARRH  = 2;
  localparam int R_DAR   = 3;
  localparam int R_DELTA = 4;

  // Anomaly points, gates and level thresholds.
  localparam int PT_FALL    = 50;
  localparam int PT_HYPOX   = 30;
  localparam int PT_ARRH    = 25;
  localparam int PT_DAR     = 35;
  localparam int PT_DELTA   = 20;
  localparam int RAW_CAP    = 100;
  localparam int ANOM_PTS   = 30;
  localparam int SQ_LIMIT   = 50;
  localparam int CRIT_AT    = 60;
  localparam int CRIT_SCORE = 75;
  localparam int WARN_AT    = 30;
  localparam int REPORT_AT  = 25;

  // Exponential average weights out of 2^16.
  localparam logic [63:0] KEEP_WT   = 64'd42598;
  localparam logic [63:0] NEW_WT    = 64'd22938;
  localparam int          SHIFT_WT  = 16;

  // Register indexes that the block does not implement.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam int PIPE_DRAIN  = 6;
  localparam int LONG_HOLD   = 80;
  localparam int QUIET_LIMIT = 5000;
  localparam int SEG_ITEMS   = 165;

  typedef struct packed {
    logic [FLAGS_W-1:0] flags;
    logic [SPO2_W-1:0]  spo2;
    logic [HR_W-1:0]    hr;
    logic [SQ_W-1:0]    sq;
    logic [DAR_W-1:0]   dar;
    logic [PW-1:0]      delta;
    logic [PW-1:0]      theta;
    logic [PW-1:0]      lo_alpha;
    logic [PW-1:0]      hi_alpha;
    logic [PW-1:0]      lo_beta;
    logic [PW-1:0]      hi_beta;
  } vitals_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [SCORE_W-1:0] score;
    logic [MASK_W-1:0]  mask;
    logic [SCORE_W-1:0] raw;
  } verdict_t;

  // Tracks thresholds, persistence and the score average, and holds the
  // verdicts still owed by the block.
  class risk_tracker;
    cfg_t        regs;
    int unsigned streak;
    logic [63:0] avg_q;
    verdict_t    expected_verdicts[$];
    int unsigned mismatches;

    function new();
      regs.spo2_hypoxia_pct    = 7'd92;
      regs.hr_brady_bpm        = 8'd40;
      regs.hr_tachy_bpm        = 8'd150;
      regs.dar_alert_level     = 16'd768;
      regs.delta_dominance_pct = 7'd50;
      regs.persistence_samples = 4'd4;
      streak     = 0;
      avg_q      = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_SPO2_HYPOXIA: regs.spo2_hypoxia_pct    = data[SPO2_W-1:0];
        REG_HR_BRADY:     regs.hr_brady_bpm        = data[HR_W-1:0];
        REG_HR_TACHY:     regs.hr_tachy_bpm        = data[HR_W-1:0];
        REG_DAR_ALERT:    regs.dar_alert_level     = data;
        REG_DELTA_DOM:    regs.delta_dominance_pct = data[PCT_W-1:0];
        REG_PERSISTENCE:  regs.persistence_samples = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending_count();
      return expected_verdicts.size();
    endfunction

    // Score one accepted sensor word and queue the verdict it must produce.
    function void note_sample(vitals_t v);
      logic [63:0]       band_sum;
      logic [63:0]       pts;
      logic [63:0]       fin;
      logic [MASK_W-1:0] why;
      logic              fall;
      logic              persistent;
      verdict_t          want;
      band_sum = 64'(v.delta) + 64'(v.theta) + 64'(v.lo_alpha) + 64'(v.hi_alpha)
               + 64'(v.lo_beta) + 64'(v.hi_beta);
      pts = '0;
      why = '0;
      fall = v.flags[F_IMU] && v.flags[F_FALL];
      if (fall) begin
        pts += PT_FALL;
        why[R_FALL] = 1'b1;
      end
      // Pulse oximeter tests need the sensor online and attached.
      if (v.flags[F_PPG] && v.flags[F_ATT]) begin
        if (v.spo2 != 0 && v.spo2 < regs.spo2_hypoxia_pct) begin
          pts += PT_HYPOX;
          why[R_HYPOX] = 1'b1;
        end
        if (v.hr != 0 && (v.hr < regs.hr_brady_bpm || v.hr > regs.hr_tachy_bpm)) begin
          pts += PT_ARRH;
          why[R_ARRH] = 1'b1;
        end
      end
      // EEG tests need a clean, synced signal.
      if (v.flags[F_EEG] && v.flags[F_SYNC] && v.sq <= SQ_LIMIT) begin
        if (v.dar >= regs.dar_alert_level) begin
          pts += PT_DAR;
          why[R_DAR] = 1'b1;
        end
        if (band_sum != 0 &&
            64'(v.delta) * 64'd100 > 64'(regs.delta_dominance_pct) * band_sum) begin
          pts += PT_DELTA;
          why[R_DELTA] = 1'b1;
        end
      end
      if (pts > RAW_CAP) pts = RAW_CAP;

      // Persistence counter saturates at zero and at the count limit.
      if (pts >= ANOM_PTS) begin
        if (streak < CNT_LIMIT) streak++;
      end else if (streak > 0) begin
        streak--;
      end

      avg_q = (avg_q * KEEP_WT + (pts << FRAC) * NEW_WT) >> SHIFT_WT;
      fin = avg_q >> FRAC;
      persistent = streak >= regs.persistence_samples;

      if (fall || (fin >= CRIT_AT && persistent)) begin
        want.level = LEVEL_CRITICAL;
        want.score = (fin > CRIT_AT) ? SCORE_W'(fin) : SCORE_W'(CRIT_SCORE);
      end else if (fin >= WARN_AT && persistent) begin
        want.level = LEVEL_WARNING;
        want.score = SCORE_W'(fin);
      end else begin
        want.level = LEVEL_NORMAL;
        want.score = (fin < REPORT_AT) ? '0 : SCORE_W'(fin / 2);
      end
      want.mask = why;
      want.raw  = SCORE_W'(pts);
      expected_verdicts.push_back(want);
    endfunction

    // Compare one result word with the oldest verdict owed.
    function void check_result(verdict_t got);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: level %0d score %0d mask %b raw %0d",
                   got.level, got.score, got.mask, got.raw);
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.level !== want.level || got.score !== want.score ||
          got.mask !== want.mask || got.raw !== want.raw) begin
        mismatches++;
        if (mismatches <= 10)
          $display("risk mismatch: exp level %0d score %0d mask %b raw %0d, %s %0d %0d %b %0d",
                   want.level, want.score, want.mask, want.raw, "got",
                   got.level, got.score, got.mask, got.raw);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [FLAGS_W-1:0]   in_sensor_flags     = '0;
  logic [SPO2_W-1:0]    in_spo2_pct         = '0;
  logic [HR_W-1:0]      in_heart_rate       = '0;
  logic [SQ_W-1:0]      in_signal_quality   = '0;
  logic [DAR_W-1:0]     in_dar_ratio        = '0;
  logic [PW-1:0]        in_delta_power      = '0;
  logic [PW-1:0]        in_theta_power      = '0;
  logic [PW-1:0]        in_low_alpha_power  = '0;
  logic [PW-1:0]        in_high_alpha_power = '0;
  logic [PW-1:0]        in_low_beta_power   = '0;
  logic [PW-1:0]        in_high_beta_power  = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [LEVEL_W-1:0]   out_risk_level;
  logic [SCORE_W-1:0]   out_risk_score;
  logic [MASK_W-1:0]    out_reason_mask;
  logic [SCORE_W-1:0]   out_raw_score;

  risk_tracker tracker;
  int          src_idle_pct  = 0;
  int          sink_idle_pct = 0;
  bit          hold_ask      = 1'b0;
  bit          hold_seen     = 1'b0;
  int          hold_left     = 0;
  int          quiet_cycles  = 0;

  vital_sign_risk_classifier u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sensor_flags     (in_sensor_flags),
    .in_spo2_pct         (in_spo2_pct),
    .in_heart_rate       (in_heart_rate),
    .in_signal_quality   (in_signal_quality),
    .in_dar_ratio        (in_dar_ratio),
    .in_delta_power      (in_delta_power),
    .in_theta_power      (in_theta_power),
    .in_low_alpha_power  (in_low_alpha_power),
    .in_high_alpha_power (in_high_alpha_power),
    .in_low_beta_power   (in_low_beta_power),
    .in_high_beta_power  (in_high_beta_power),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_risk_level      (out_risk_level),
    .out_risk_score      (out_risk_score),
    .out_reason_mask     (out_reason_mask),
    .out_raw_score       (out_raw_score)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: check every word taken, then pick the next stall value.
  // A toggle of hold_ask starts one long hold-off.
  always @(posedge clk) begin : result_sink
    verdict_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_risk_level, out_risk_score, out_reason_mask, out_raw_score};
      tracker.check_result(got);
    end
    if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  // Watchdog on cycles where neither channel moves a word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[vital_sign_risk_classifier] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int clip(int x, int hi);
    if (x < 0) return 0;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic logic [PW-1:0] rand_band();
    case ($urandom_range(4))
      0:       return '0;
      1:       return PW'($urandom_range(255));
      2:       return PW'($urandom_range(65535));
      3:       return PW'($urandom);
      default: return '1;
    endcase
  endfunction

  // Build one random sensor word. Most words have every sensor online so
  // that the tests are reached; distress words push the score up.
  function automatic vitals_t make_vitals(bit distress);
    vitals_t v;
    int      t;
    int      flip;
    if ($urandom_range(9) == 0) begin
      // Noise: every field random, with SpO2 kept within 0 to 100.
      v.flags    = FLAGS_W'($urandom);
      v.spo2     = SPO2_W'($urandom_range(100));
      v.hr       = HR_W'($urandom);
      v.sq       = SQ_W'($urandom);
      v.dar      = DAR_W'($urandom);
      v.delta    = PW'($urandom);
      v.theta    = PW'($urandom);
      v.lo_alpha = PW'($urandom);
      v.hi_alpha = PW'($urandom);
      v.lo_beta  = PW'($urandom);
      v.hi_beta  = PW'($urandom);
      return v;
    end

    v.flags = '1;
    v.flags[F_FALL] = ($urandom_range(99) < (distress ? 25 : 3));
    if ($urandom_range(7) == 0) begin
      flip = $urandom_range(FLAGS_W - 1);
      v.flags[flip] = ~v.flags[flip];
    end

    t = tracker.regs.spo2_hypoxia_pct;
    case ($urandom_range(3))
      0:       v.spo2 = SPO2_W'($urandom_range(100));
      1:       v.spo2 = SPO2_W'(clip(t - 1 + int'($urandom_range(2)), 100));
      default: v.spo2 = distress ? SPO2_W'($urandom_range(90, 40))
                                 : SPO2_W'($urandom_range(100, 93));
    endcase

    case ($urandom_range(3))
      0: v.hr = HR_W'($urandom);
      1: v.hr = HR_W'(clip(int'(tracker.regs.hr_brady_bpm) - 1 + int'($urandom_range(2)), 255));
      2: v.hr = HR_W'(clip(int'(tracker.regs.hr_tachy_bpm) - 1 + int'($urandom_range(2)), 255));
      default: v.hr = distress ? HR_W'($urandom_range(255, 160))
                               : HR_W'($urandom_range(120, 50));
    endcase

    v.sq = ($urandom_range(4) == 0) ? SQ_W'($urandom) : SQ_W'($urandom_range(60));

    t = tracker.regs.dar_alert_level;
    case ($urandom_range(2))
      0:       v.dar = DAR_W'($urandom);
      1:       v.dar = DAR_W'(clip(t - 1 + int'($urandom_range(2)), 65535));
      default: v.dar = distress ? DAR_W'(clip(t + int'($urandom_range(4000)), 65535))
                                : DAR_W'(clip(t - 1 - int'($urandom_range(1000)), 65535));
    endcase

    v.delta    = rand_band();
    v.theta    = rand_band();
    v.lo_alpha = rand_band();
    v.hi_alpha = rand_band();
    v.lo_beta  = rand_band();
    v.hi_beta  = rand_band();
    if (distress) v.delta = v.delta | (PW'(1) << (PW - 1));
    return v;
  endfunction

  // Offer one word after a random idle gap and hold it until it is taken.
  task automatic offer(vitals_t v);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_sensor_flags     <= v.flags;
    in_spo2_pct         <= v.spo2;
    in_heart_rate       <= v.hr;
    in_signal_quality   <= v.sq;
    in_dar_ratio        <= v.dar;
    in_delta_power      <= v.delta;
    in_theta_power      <= v.theta;
    in_low_alpha_power  <= v.lo_alpha;
    in_high_alpha_power <= v.hi_alpha;
    in_low_beta_power   <= v.lo_beta;
    in_high_beta_power  <= v.hi_beta;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_sample(v);
  endtask

  // Wait until every owed verdict has come back and the pipeline is empty.
  task automatic settle();
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // One register write; bits above a narrow register carry random junk.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val, int w);
    logic [CFG_W-1:0] data;
    data = CFG_W'(val);
    if (w < CFG_W) data = data | (CFG_W'($urandom) << w);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.set_reg(idx, data);
  endtask

  task automatic apply_setting(int k);
    case (k)
      0: begin
        // Defaults written explicitly, plus a write to a missing register.
        write_reg(REG_SPO2_HYPOXIA, 92, SPO2_W);
        write_reg(REG_HR_BRADY, 40, HR_W);
        write_reg(REG_HR_TACHY, 150, HR_W);
        write_reg(REG_DAR_ALERT, 768, DAR_W);
        write_reg(REG_DELTA_DOM, 50, PCT_W);
        write_reg(REG_PERSISTENCE, 4, CNT_W);
        write_reg(REG_SPARE_6, $urandom, CFG_W);
      end
      1: begin
        write_reg(REG_SPO2_HYPOXIA, 0, SPO2_W);
        write_reg(REG_HR_BRADY, 0, HR_W);
        write_reg(REG_HR_TACHY, 0, HR_W);
        write_reg(REG_DAR_ALERT, 0, DAR_W);
        write_reg(REG_DELTA_DOM, 0, PCT_W);
        write_reg(REG_PERSISTENCE, 1, CNT_W);
      end
      2: begin
        write_reg(REG_SPO2_HYPOXIA, 100, SPO2_W);
        write_reg(REG_HR_BRADY, 255, HR_W);
        write_reg(REG_HR_TACHY, 255, HR_W);
        write_reg(REG_DAR_ALERT, 65535, DAR_W);
        write_reg(REG_DELTA_DOM, 100, PCT_W);
        write_reg(REG_PERSISTENCE, CNT_LIMIT, CNT_W);
      end
      3: begin
        // Values past the stated ranges; persistence zero means always.
        write_reg(REG_SPO2_HYPOXIA, 127, SPO2_W);
        write_reg(REG_HR_BRADY, 60, HR_W);
        write_reg(REG_HR_TACHY, 100, HR_W);
        write_reg(REG_DAR_ALERT, 0, DAR_W);
        write_reg(REG_DELTA_DOM, 127, PCT_W);
        write_reg(REG_PERSISTENCE, 0, CNT_W);
        write_reg(REG_SPARE_7, $urandom, CFG_W);
      end
      default: begin
        write_reg(REG_SPO2_HYPOXIA, $urandom_range(100), SPO2_W);
        write_reg(REG_HR_BRADY, $urandom_range(70, 30), HR_W);
        write_reg(REG_HR_TACHY, $urandom_range(200, 100), HR_W);
        write_reg(REG_DAR_ALERT, $urandom_range(2048), DAR_W);
        write_reg(REG_DELTA_DOM, $urandom_range(100), PCT_W);
        // A persistence value past the counter limit never counts.
        write_reg(REG_PERSISTENCE, (k == 4) ? 15 : $urandom_range(CNT_LIMIT, 1), CNT_W);
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  // Directed words under the reset thresholds: field extremes, each test
  // just inside and just outside its threshold, the gates, and a short
  // run of maximal anomalies that makes the level persistent.
  task automatic directed_samples();
    vitals_t base;
    vitals_t v;
    base = '0;
    base.flags = '1;
    base.flags[F_FALL] = 1'b0;
    base.spo2 = 7'd98;
    base.hr = 8'd70;
    base.sq = 8'd20;
    base.dar = 16'd256;
    base.delta = PW'(100);
    base.theta = PW'(100);
    base.lo_alpha = PW'(100);
    base.hi_alpha = PW'(100);
    base.lo_beta = PW'(100);
    base.hi_beta = PW'(100);

    v = '0;
    offer(v);
    v = '1;
    v.spo2 = 7'd100;
    offer(v);
    offer(base);
    v = base;
    v.flags[F_FALL] = 1'b1;
    offer(v);
    // Fall bit without the IMU online does not count.
    v.flags[F_IMU] = 1'b0;
    offer(v);

    v = base;
    v.spo2 = 7'd0;
    offer(v);
    v.spo2 = 7'd91;
    offer(v);
    v.spo2 = 7'd92;
    offer(v);

    v = base;
    v.hr = 8'd0;
    offer(v);
    v.hr = 8'd39;
    offer(v);
    v.hr = 8'd40;
    offer(v);
    v.hr = 8'd150;
    offer(v);
    v.hr = 8'd151;
    offer(v);

    v = base;
    v.dar = 16'd768;
    v.sq = 8'd50;
    offer(v);
    v.sq = 8'd51;
    offer(v);
    v.sq = 8'd50;
    v.dar = 16'd767;
    offer(v);

    // Delta share exactly at the limit, then just above it.
    v = base;
    v.delta = PW'(500);
    v.theta = PW'(500);
    v.lo_alpha = '0;
    v.hi_alpha = '0;
    v.lo_beta = '0;
    v.hi_beta = '0;
    offer(v);
    v.delta = PW'(501);
    offer(v);
    // Zero total power never counts as delta dominance.
    v.delta = '0;
    v.theta = '0;
    offer(v);
    // Full-scale bands: the total must not wrap.
    v = base;
    v.delta = '1;
    v.theta = '1;
    v.lo_alpha = '1;
    v.hi_alpha = '1;
    v.lo_beta = '1;
    v.hi_beta = '1;
    offer(v);
    // Oximeter detached: its tests are gated off.
    v = base;
    v.flags[F_ATT] = 1'b0;
    v.spo2 = 7'd50;
    v.hr = 8'd200;
    offer(v);

    v = base;
    v.spo2 = 7'd80;
    v.hr = 8'd200;
    v.dar = 16'hFFFF;
    v.delta = '1;
    repeat (4) offer(v);
  endtask

  initial begin : stimulus
    vitals_t v;
    int      seg;
    int      n;
    int      episode_left;
    bit      distress;
    tracker = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    src_idle_pct = 16;
    sink_idle_pct <= 79;
    @(posedge clk);
    directed_samples();

    episode_left = 0;
    distress = 1'b0;
    for (seg = 0; seg < 6; seg++) begin
      in_valid <= 1'b0;
      settle();
      apply_setting(seg);
      // Sender busy and receiver slow, then the reverse, then full speed.
      if (seg < 2) begin
        src_idle_pct = 16;
        sink_idle_pct <= 79;
      end else if (seg < 4) begin
        src_idle_pct = 79;
        sink_idle_pct <= 16;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct <= 0;
      end
      // Long receiver hold-off while the sender keeps offering words.
      if (seg == 4) hold_ask <= ~hold_ask;
      for (n = 0; n < SEG_ITEMS; n++) begin
        if (episode_left == 0) begin
          distress = ($urandom_range(2) == 0);
          episode_left = $urandom_range(30, 5);
        end
        episode_left--;
        v = make_vitals(distress);
        offer(v);
      end
    end

    in_valid <= 1'b0;
    settle();
    if (tracker.mismatches == 0 && tracker.pending_count() == 0)
      $display("[vital_sign_risk_classifier] OK");
    else
      $display("[vital_sign_risk_classifier] ERROR");
    $finish;
  end

endmodule

// ----- vital_sign_risk_classifier.f -----
rtl/core/vsrc_pkg.sv
rtl/core/vsrc_cfg_regs.sv
rtl/core/vsrc_detect.sv
rtl/core/vsrc_trend.sv
rtl/core/vsrc_grade.sv
rtl/core/vital_sign_risk_classifier.sv
test/tb_vital_sign_risk_classifier.sv
